### hw/rtl/dzpv_pkg.sv
// Shared types and constants for the deadzone proportional velocity controller.
package dzpv_pkg;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HALF_VIEW_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_DEADZONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SETPOINT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_DEADZONE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_GAIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LATERAL_GAIN    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LIMIT    = 3'd7;

  // Command modes.
  localparam logic [2:0] CMD_FOLLOW = 3'd1;
  localparam logic [2:0] CMD_LEFT   = 3'd2;
  localparam logic [2:0] CMD_RIGHT  = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;

  // Fixed Q4.12 speeds.
  localparam logic [15:0] ROT_LIMIT  = 16'd6144;  // 1.5
  localparam logic [15:0] ROT_FIXED  = 16'd2048;  // 0.5
  localparam logic [15:0] SEARCH_ROT = 16'd3277;  // 0.8

  // Configuration register file contents.
  typedef struct packed {
    logic [14:0] half_view_width;
    logic [14:0] rotate_deadzone;
    logic [23:0] rotate_gain;
    logic [14:0] depth_setpoint;
    logic [14:0] depth_deadzone;
    logic [14:0] forward_gain;
    logic [14:0] lateral_gain;
    logic [14:0] linear_limit;
  } cfg_t;

  // Mode bits that travel with every request.
  typedef struct packed {
    logic       found;
    logic [2:0] cmd;
  } ctl_t;

  // Error magnitudes and signs, front end to scaler.
  typedef struct packed {
    ctl_t        ctl;
    logic [16:0] e4_mag;
    logic        e4_neg;
    logic [16:0] d_mag;
    logic        d_neg;
    logic        fwd_act;
    logic [15:0] x_mag;
    logic        x_neg;
  } err_t;

  // Rounded speed magnitudes, scaler to output stage.
  typedef struct packed {
    ctl_t        ctl;
    logic        rot_act;
    logic        rot_neg;
    logic [19:0] rot_mag;
    logic        fwd_act;
    logic        fwd_neg;
    logic [20:0] fwd_mag;
    logic        lat_neg;
    logic [19:0] lat_mag;
  } mag_t;

endpackage

### hw/rtl/dzpv_cfg.sv
// Configuration register file for the velocity controller.
module dzpv_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dzpv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dzpv_pkg::CFG_DATA_W-1:0] cfg_data,
  output dzpv_pkg::cfg_t                 cfg
);
  import dzpv_pkg::*;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Register writes, with the documented reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_view_width <= 15'd15360;
      cfg.rotate_deadzone <= 15'd800;
      cfg.rotate_gain     <= 24'd699051;
      cfg.depth_setpoint  <= 15'd1229;
      cfg.depth_deadzone  <= 15'd205;
      cfg.forward_gain    <= 15'd4915;
      cfg.lateral_gain    <= 15'd4096;
      cfg.linear_limit    <= 15'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_VIEW_WIDTH: cfg.half_view_width <= cfg_data[14:0];
        REG_ROTATE_DEADZONE: cfg.rotate_deadzone <= cfg_data[14:0];
        REG_ROTATE_GAIN:     cfg.rotate_gain     <= cfg_data;
        REG_DEPTH_SETPOINT:  cfg.depth_setpoint  <= cfg_data[14:0];
        REG_DEPTH_DEADZONE:  cfg.depth_deadzone  <= cfg_data[14:0];
        REG_FORWARD_GAIN:    cfg.forward_gain    <= cfg_data[14:0];
        REG_LATERAL_GAIN:    cfg.lateral_gain    <= cfg_data[14:0];
        REG_LINEAR_LIMIT:    cfg.linear_limit    <= cfg_data[14:0];
      endcase
    end
  end

endmodule

### hw/rtl/dzpv_front.sv
// Front end stages: corner sum, errors, magnitudes and the depth deadzone.
module dzpv_front (
  input  logic                clk,
  input  logic                rst,
  input  dzpv_pkg::cfg_t      cfg,
  input  logic                in_vld,
  input  logic                target_found,
  input  logic [2:0]          command,
  input  logic signed [15:0]  cam_x,
  input  logic signed [15:0]  cam_z,
  input  logic [14:0]         corner_x0,
  input  logic [14:0]         corner_x1,
  input  logic [14:0]         corner_x2,
  input  logic [14:0]         corner_x3,
  output logic                err_vld,
  output dzpv_pkg::err_t      err
);
  import dzpv_pkg::*;

  // Stage one registers.
  logic               s1_vld;
  ctl_t               s1_ctl;
  logic [16:0]        s1_sum;
  logic signed [16:0] s1_d;
  logic [15:0]        s1_x_mag;
  logic               s1_x_neg;

  // Stage two combinational terms.
  logic signed [17:0] e4;
  logic [16:0]        e4_mag;
  logic [16:0]        d_mag;

  // Valid bits advance every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      err_vld <= 1'b0;
    end else begin
      s1_vld  <= in_vld;
      err_vld <= s1_vld;
    end
  end

  // Stage one: corner sum, depth error and offset magnitude.
  always_ff @(posedge clk) begin
    s1_ctl.found <= target_found;
    s1_ctl.cmd   <= command;
    s1_sum       <= 17'(corner_x0) + 17'(corner_x1) + 17'(corner_x2) + 17'(corner_x3);
    s1_d         <= $signed({cam_z[15], cam_z}) - $signed({2'b00, cfg.depth_setpoint});
    s1_x_neg     <= cam_x[15];
    s1_x_mag     <= cam_x[15] ? (~cam_x + 16'sd1) : cam_x;
  end

  // Four times the pixel error and its magnitude.
  assign e4     = $signed({1'b0, cfg.half_view_width, 2'b00}) - $signed({1'b0, s1_sum});
  assign e4_mag = e4[17] ? 17'(~e4 + 18'sd1) : e4[16:0];
  assign d_mag  = s1_d[16] ? 17'(~s1_d + 17'sd1) : s1_d[16:0];

  // Stage two: magnitudes and the depth deadzone test.
  always_ff @(posedge clk) begin
    err.ctl     <= s1_ctl;
    err.e4_mag  <= e4_mag;
    err.e4_neg  <= e4[17];
    err.d_mag   <= d_mag;
    err.d_neg   <= s1_d[16];
    err.fwd_act <= d_mag > {2'b00, cfg.depth_deadzone};
    err.x_mag   <= s1_x_mag;
    err.x_neg   <= s1_x_neg;
  end

endmodule

### hw/rtl/dzpv_scale.sv
// Gain stages: one multiplier per axis, then round half away from zero.
module dzpv_scale (
  input  logic           clk,
  input  logic           rst,
  input  dzpv_pkg::cfg_t cfg,
  input  logic           err_vld,
  input  dzpv_pkg::err_t err,
  output logic           mag_vld,
  output dzpv_pkg::mag_t mag
);
  import dzpv_pkg::*;

  // Stage three registers: raw products.
  logic        s3_vld;
  ctl_t        s3_ctl;
  logic [40:0] s3_rot_prod;
  logic [31:0] s3_fwd_prod;
  logic [30:0] s3_lat_prod;
  logic        s3_rot_act;
  logic        s3_rot_neg;
  logic        s3_fwd_act;
  logic        s3_fwd_neg;
  logic        s3_lat_neg;

  // Rounding sums.
  logic [41:0] rot_sum;
  logic [32:0] fwd_sum;
  logic [31:0] lat_sum_half;
  logic [31:0] lat_sum_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld  <= 1'b0;
      mag_vld <= 1'b0;
    end else begin
      s3_vld  <= err_vld;
      mag_vld <= s3_vld;
    end
  end

  // Stage three: multiply magnitudes by gains; rotation deadzone test.
  always_ff @(posedge clk) begin
    s3_ctl      <= err.ctl;
    s3_rot_prod <= 41'(err.e4_mag) * 41'(cfg.rotate_gain);
    s3_fwd_prod <= 32'(err.d_mag) * 32'(cfg.forward_gain);
    s3_lat_prod <= 31'(err.x_mag) * 31'(cfg.lateral_gain);
    s3_rot_act  <= err.e4_mag > {cfg.rotate_deadzone, 2'b00};
    s3_rot_neg  <= err.e4_neg;
    s3_fwd_act  <= err.fwd_act;
    s3_fwd_neg  <= err.d_neg;
    s3_lat_neg  <= err.x_neg;
  end

  // Add half an output step before the shift.
  assign rot_sum      = {1'b0, s3_rot_prod} + (42'd1 << 21);
  assign fwd_sum      = {1'b0, s3_fwd_prod} + 33'd2048;
  assign lat_sum_full = {1'b0, s3_lat_prod} + 32'd2048;
  assign lat_sum_half = {1'b0, s3_lat_prod} + 32'd4096;

  // Stage four: rounded magnitudes; follow mode uses half gain.
  always_ff @(posedge clk) begin
    mag.ctl     <= s3_ctl;
    mag.rot_act <= s3_rot_act;
    mag.rot_neg <= s3_rot_neg;
    mag.rot_mag <= rot_sum[41:22];
    mag.fwd_act <= s3_fwd_act;
    mag.fwd_neg <= s3_fwd_neg;
    mag.fwd_mag <= fwd_sum[32:12];
    mag.lat_neg <= s3_lat_neg;
    if (s3_ctl.cmd == CMD_FOLLOW) begin
      mag.lat_mag <= {1'b0, lat_sum_half[31:13]};
    end else begin
      mag.lat_mag <= lat_sum_full[31:12];
    end
  end

endmodule

### hw/rtl/dzpv_output.sv
// Output stage: clamps, signs, mode overrides and the result register.
module dzpv_output (
  input  logic               clk,
  input  logic               rst,
  input  dzpv_pkg::cfg_t     cfg,
  input  logic               mag_vld,
  input  dzpv_pkg::mag_t     mag,
  output logic               done,
  output logic signed [15:0] lateral_speed,
  output logic signed [15:0] forward_speed,
  output logic signed [15:0] rotation_speed
);
  import dzpv_pkg::*;

  logic [16:0] rot_c;
  logic [16:0] fwd_c;
  logic [16:0] lat_c;
  logic [15:0] rot_v;
  logic [15:0] fwd_v;
  logic [15:0] lat_v;
  logic [15:0] lat_next;
  logic [15:0] fwd_next;
  logic [15:0] rot_next;

  // Negate a clamped magnitude into a 16-bit two's complement value.
  function automatic logic [15:0] apply_sign(input logic [16:0] m, input logic neg);
    logic [16:0] t;
    t = neg ? (~m + 17'd1) : m;
    return t[15:0];
  endfunction

  // Clamp the magnitudes; follow-mode lateral saturates to the Q4.12 range.
  always_comb begin
    rot_c = (mag.rot_mag > {4'b0, ROT_LIMIT}) ? {1'b0, ROT_LIMIT} : mag.rot_mag[16:0];
    fwd_c = (mag.fwd_mag > {6'b0, cfg.linear_limit}) ? {2'b0, cfg.linear_limit}
                                                      : mag.fwd_mag[16:0];
    if (mag.ctl.cmd == CMD_FOLLOW) begin
      if (mag.lat_neg) begin
        lat_c = (mag.lat_mag > 20'd32768) ? 17'd32768 : mag.lat_mag[16:0];
      end else begin
        lat_c = (mag.lat_mag > 20'd32767) ? 17'd32767 : mag.lat_mag[16:0];
      end
    end else begin
      lat_c = (mag.lat_mag > {5'b0, cfg.linear_limit}) ? {2'b0, cfg.linear_limit}
                                                        : mag.lat_mag[16:0];
    end
    rot_v = mag.rot_act ? apply_sign(rot_c, mag.rot_neg) : 16'd0;
    fwd_v = mag.fwd_act ? apply_sign(fwd_c, mag.fwd_neg) : 16'd0;
    lat_v = apply_sign(lat_c, mag.lat_neg);
  end

  // Search spin and fixed modes override the computed speeds.
  always_comb begin
    lat_next = lat_v;
    fwd_next = fwd_v;
    rot_next = rot_v;
    if (!mag.ctl.found) begin
      lat_next = 16'd0;
      fwd_next = 16'd0;
      rot_next = SEARCH_ROT;
    end else begin
      case (mag.ctl.cmd)
        CMD_LEFT: begin
          lat_next = 16'd0;
          fwd_next = 16'd0;
          rot_next = ROT_FIXED;
        end
        CMD_RIGHT: begin
          lat_next = 16'd0;
          fwd_next = 16'd0;
          rot_next = ~ROT_FIXED + 16'd1;
        end
        CMD_STOP: begin
          lat_next = 16'd0;
          fwd_next = 16'd0;
          rot_next = 16'd0;
        end
        default: begin
          lat_next = lat_v;
          fwd_next = fwd_v;
          rot_next = rot_v;
        end
      endcase
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mag_vld;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    lateral_speed  <= $signed(lat_next);
    forward_speed  <= $signed(fwd_next);
    rotation_speed <= $signed(rot_next);
  end

`ifndef SYNTHESIS
  // Rotation never leaves +-1.5.
  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (rotation_speed <= 16'sd6144 && rotation_speed >= -16'sd6144))
    else $error("rotation speed outside clamp");

  // The forward speed stays within the linear limit in every mode.
  a_fwd_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (forward_speed <= $signed({1'b0, $past(cfg.linear_limit)})
              && forward_speed >= -$signed({1'b0, $past(cfg.linear_limit)})))
    else $error("forward speed outside limit");
`endif

endmodule

### hw/rtl/deadzone_p_velocity_controller.sv
// Top level of the deadzone proportional velocity controller.
//
//  channel   signals                                    direction  accepted when
//  request   start, busy, target_found .. corner_x3     in         start && !busy
//  result    done, lateral/forward/rotation_speed       out        every cycle done is high
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in         cfg_valid && cfg_ready
//
// Each accepted request gives its result at the end of the pipeline; one request
// can be accepted every cycle. The five register stages are error terms,
// magnitudes, multipliers, rounding, and clamp/select. busy is high during reset
// and for the first cycle after it; nothing stalls the pipeline, as results are
// not held off. Reset clears the stage valid bits and loads the register defaults.
module deadzone_p_velocity_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           target_found,
  input  logic [2:0]                     command,
  input  logic signed [15:0]             cam_x,
  input  logic signed [15:0]             cam_z,
  input  logic [14:0]                    corner_x0,
  input  logic [14:0]                    corner_x1,
  input  logic [14:0]                    corner_x2,
  input  logic [14:0]                    corner_x3,
  output logic                           done,
  output logic signed [15:0]             lateral_speed,
  output logic signed [15:0]             forward_speed,
  output logic signed [15:0]             rotation_speed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dzpv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dzpv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dzpv_pkg::*;

  cfg_t cfg;
  logic in_vld;
  logic err_vld;
  err_t err;
  logic mag_vld;
  mag_t mag;

  // Busy only while coming out of reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign in_vld = start && !busy;

  dzpv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dzpv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_vld       (in_vld),
    .target_found (target_found),
    .command      (command),
    .cam_x        (cam_x),
    .cam_z        (cam_z),
    .corner_x0    (corner_x0),
    .corner_x1    (corner_x1),
    .corner_x2    (corner_x2),
    .corner_x3    (corner_x3),
    .err_vld      (err_vld),
    .err          (err)
  );

  dzpv_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .err_vld (err_vld),
    .err     (err),
    .mag_vld (mag_vld),
    .mag     (mag)
  );

  dzpv_output u_output (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .mag_vld        (mag_vld),
    .mag            (mag),
    .done           (done),
    .lateral_speed  (lateral_speed),
    .forward_speed  (forward_speed),
    .rotation_speed (rotation_speed)
  );

`ifndef SYNTHESIS
  // Every accepted request gives exactly one result at the end of the pipeline.
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted request produced no result");

  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without a matching request");

  // A lost target gives the search spin and no linear motion.
  a_search_spin: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !target_found) |-> ##5
      (rotation_speed == SEARCH_ROT && forward_speed == 16'sd0 && lateral_speed == 16'sd0))
    else $error("search spin result wrong");
`endif

endmodule

### bench/tb_deadzone_p_velocity_controller.sv
// Self-checking bench for the deadzone proportional velocity controller.
`timescale 1ns / 100ps

module tb_deadzone_p_velocity_controller;
  import dzpv_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;     // pipeline is five stages deep
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned QUIET_TAIL    = 150;
  localparam longint      SPEED_MAX     = 32767;
  localparam longint      SPEED_MIN     = -32768;

  // Docking modes and the two undefined codes.
  localparam logic [2:0] CMD_DOCK_A   = 3'd5;
  localparam logic [2:0] CMD_DOCK_B   = 3'd6;
  localparam logic [2:0] CMD_UNDEF_LO = 3'd0;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  // One camera frame as presented on the request ports.
  typedef struct packed {
    logic               target_found;
    logic [2:0]         command;
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_z;
    logic [3:0][14:0]   corners;
  } frame_t;

  // Velocity commands of one result.
  typedef struct packed {
    logic signed [15:0] lateral;
    logic signed [15:0] forward;
    logic signed [15:0] rotation;
  } speeds_t;

  // Computes the expected velocity commands and checks them in order.
  class speed_scoreboard;
    cfg_t        regs;
    speeds_t     pending_speeds[$];
    int unsigned failures;

    function new();
      regs = reset_values();
      failures = 0;
    endfunction

    function cfg_t reset_values();
      cfg_t c;
      c.half_view_width = 15'd15360;
      c.rotate_deadzone = 15'd800;
      c.rotate_gain     = 24'd699051;
      c.depth_setpoint  = 15'd1229;
      c.depth_deadzone  = 15'd205;
      c.forward_gain    = 15'd4915;
      c.lateral_gain    = 15'd4096;
      c.linear_limit    = 15'd4096;
      return c;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HALF_VIEW_WIDTH: regs.half_view_width = data[14:0];
        REG_ROTATE_DEADZONE: regs.rotate_deadzone = data[14:0];
        REG_ROTATE_GAIN:     regs.rotate_gain     = data[23:0];
        REG_DEPTH_SETPOINT:  regs.depth_setpoint  = data[14:0];
        REG_DEPTH_DEADZONE:  regs.depth_deadzone  = data[14:0];
        REG_FORWARD_GAIN:    regs.forward_gain    = data[14:0];
        REG_LATERAL_GAIN:    regs.lateral_gain    = data[14:0];
        REG_LINEAR_LIMIT:    regs.linear_limit    = data[14:0];
        default: ;
      endcase
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Scales by gain / 2^sh, rounding halves away from zero on the magnitude.
    function longint round_scaled(longint v, longint g, int sh);
      longint mag;
      mag = magnitude(v) * g;
      mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
      return (v < 0) ? -mag : mag;
    endfunction

    function longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function speeds_t predict_speeds(frame_t f);
      longint  sum, e4, d, lat, fwd, rot;
      speeds_t s;
      lat = 0;
      fwd = 0;
      rot = 0;
      if (!f.target_found) begin
        // Lost marker: search spin regardless of the command.
        rot = longint'(SEARCH_ROT);
      end else begin
        sum = 0;
        for (int k = 0; k < 4; k++) sum += longint'(f.corners[k]);
        e4 = 4 * longint'(regs.half_view_width) - sum;
        d  = longint'(f.cam_z) - longint'(regs.depth_setpoint);

        if (magnitude(e4) > 4 * longint'(regs.rotate_deadzone))
          rot = clamp_sym(round_scaled(e4, longint'(regs.rotate_gain), 22),
                          longint'(ROT_LIMIT));
        if (magnitude(d) > longint'(regs.depth_deadzone))
          fwd = clamp_sym(round_scaled(d, longint'(regs.forward_gain), 12),
                          longint'(regs.linear_limit));

        // Follow mode uses half gain, saturated to the output range.
        if (f.command != CMD_FOLLOW) begin
          lat = clamp_sym(round_scaled(longint'(f.cam_x), longint'(regs.lateral_gain), 12),
                          longint'(regs.linear_limit));
        end else begin
          lat = round_scaled(longint'(f.cam_x), longint'(regs.lateral_gain), 13);
          if (lat > SPEED_MAX) lat = SPEED_MAX;
          if (lat < SPEED_MIN) lat = SPEED_MIN;
        end

        // Fixed modes override the computed values.
        case (f.command)
          CMD_LEFT: begin
            lat = 0; fwd = 0; rot = longint'(ROT_FIXED);
          end
          CMD_RIGHT: begin
            lat = 0; fwd = 0; rot = -longint'(ROT_FIXED);
          end
          CMD_STOP: begin
            lat = 0; fwd = 0; rot = 0;
          end
          default: ;
        endcase
      end
      s.lateral  = lat[15:0];
      s.forward  = fwd[15:0];
      s.rotation = rot[15:0];
      return s;
    endfunction

    function void note_request(frame_t f);
      pending_speeds.insert(pending_speeds.size(), predict_speeds(f));
    endfunction

    function void check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic signed [15:0] lat, logic signed [15:0] fwd,
                               logic signed [15:0] rot);
      speeds_t want;
      if (pending_speeds.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got %0d %0d %0d",
                 $time, lat, fwd, rot);
        failures++;
        return;
      end
      want = pending_speeds.pop_front();
      check_field("lateral_speed", want.lateral, lat);
      check_field("forward_speed", want.forward, fwd);
      check_field("rotation_speed", want.rotation, rot);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  target_found;
  logic [2:0]            command;
  logic signed [15:0]    cam_x;
  logic signed [15:0]    cam_z;
  logic [14:0]           corner_x0;
  logic [14:0]           corner_x1;
  logic [14:0]           corner_x2;
  logic [14:0]           corner_x3;
  logic                  done;
  logic signed [15:0]    lateral_speed;
  logic signed [15:0]    forward_speed;
  logic signed [15:0]    rotation_speed;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  speed_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     idle_odds = 0;

  deadzone_p_velocity_controller i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .target_found   (target_found),
    .command        (command),
    .cam_x          (cam_x),
    .cam_z          (cam_z),
    .corner_x0      (corner_x0),
    .corner_x1      (corner_x1),
    .corner_x2      (corner_x2),
    .corner_x3      (corner_x3),
    .done           (done),
    .lateral_speed  (lateral_speed),
    .forward_speed  (forward_speed),
    .rotation_speed (rotation_speed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are taken at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(lateral_speed, forward_speed, rotation_speed);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it.
  task automatic send_request(frame_t f);
    start        <= 1'b1;
    target_found <= f.target_found;
    command      <= f.command;
    cam_x        <= f.cam_x;
    cam_z        <= f.cam_z;
    corner_x0    <= f.corners[0];
    corner_x1    <= f.corners[1];
    corner_x2    <= f.corners[2];
    corner_x3    <= f.corners[3];
    do @(posedge clk); while (busy);
    sb.note_request(f);
  endtask

  // Inserts a random idle burst on the request side.
  task automatic maybe_idle();
    if (idle_odds != 0 && $urandom_range(0, 3) < idle_odds) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_frame(bit found, logic [2:0] cmd, int x, int z,
                            int c0, int c1, int c2, int c3);
    frame_t f;
    f.target_found = found;
    f.command      = cmd;
    f.cam_x        = 16'(x);
    f.cam_z        = 16'(z);
    f.corners[0]   = 15'(c0);
    f.corners[1]   = 15'(c1);
    f.corners[2]   = 15'(c2);
    f.corners[3]   = 15'(c3);
    maybe_idle();
    send_request(f);
  endtask

  // Holds one write until it is taken; the caller drops valid afterwards.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Narrow registers get random upper bits, which the block must drop.
  task automatic cfg_write15(logic [CFG_IDX_W-1:0] idx, logic [14:0] value);
    logic [31:0] junk;
    junk = $urandom;
    cfg_write(idx, {junk[8:0], value});
  endtask

  task automatic load_settings(cfg_t c);
    cfg_write15(REG_HALF_VIEW_WIDTH, c.half_view_width);
    cfg_write15(REG_ROTATE_DEADZONE, c.rotate_deadzone);
    cfg_write(REG_ROTATE_GAIN, c.rotate_gain);
    cfg_write15(REG_DEPTH_SETPOINT, c.depth_setpoint);
    cfg_write15(REG_DEPTH_DEADZONE, c.depth_deadzone);
    cfg_write15(REG_FORWARD_GAIN, c.forward_gain);
    cfg_write15(REG_LATERAL_GAIN, c.lateral_gain);
    cfg_write15(REG_LINEAR_LIMIT, c.linear_limit);
    cfg_valid <= 1'b0;
  endtask

  // Lets every outstanding request finish before touching the registers.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending_speeds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    c.half_view_width = 15'($urandom);
    c.rotate_deadzone = 15'($urandom_range(0, 4000));
    c.rotate_gain     = 24'($urandom);
    c.depth_setpoint  = 15'($urandom);
    c.depth_deadzone  = 15'($urandom_range(0, 2000));
    c.forward_gain    = 15'($urandom);
    c.lateral_gain    = 15'($urandom);
    c.linear_limit    = 15'($urandom);
    return c;
  endfunction

  // Frames cluster around the deadzone edges of the current settings.
  function automatic frame_t random_frame();
    frame_t      f;
    longint      e4, s, off, depth_val;
    int unsigned pick;
    f.target_found = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 15);
    if (pick < 6) f.command = CMD_FOLLOW;
    else if (pick < 12) f.command = $urandom_range(0, 1) ? CMD_DOCK_A : CMD_DOCK_B;
    else f.command = 3'($urandom_range(0, 7));
    f.cam_x = 16'($urandom);

    if ($urandom_range(0, 2) == 0) begin
      for (int k = 0; k < 4; k++) f.corners[k] = 15'($urandom);
    end else begin
      if ($urandom_range(0, 1))
        e4 = 4 * longint'(sb.regs.rotate_deadzone) + longint'($urandom_range(0, 8)) - 4;
      else
        e4 = longint'($urandom_range(0, 4 * sb.regs.rotate_deadzone + 256));
      if ($urandom_range(0, 1)) e4 = -e4;
      s = 4 * longint'(sb.regs.half_view_width) - e4;
      if (s < 0) s = 0;
      if (s > 4 * 32767) s = 4 * 32767;
      for (int k = 0; k < 3; k++) f.corners[k] = 15'(s / 4);
      f.corners[3] = 15'(s - 3 * (s / 4));
    end

    if ($urandom_range(0, 2) == 0) begin
      f.cam_z = 16'($urandom);
    end else begin
      if ($urandom_range(0, 1))
        off = longint'(sb.regs.depth_deadzone) + longint'($urandom_range(0, 4)) - 2;
      else
        off = longint'($urandom_range(0, sb.regs.depth_deadzone + 500));
      if ($urandom_range(0, 1)) off = -off;
      depth_val = longint'(sb.regs.depth_setpoint) + off;
      if (depth_val > SPEED_MAX) depth_val = SPEED_MAX;
      if (depth_val < SPEED_MIN) depth_val = SPEED_MIN;
      f.cam_z = 16'(depth_val);
    end
    return f;
  endfunction

  task automatic run_random(int unsigned count, bit quiet_tail);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) idle_odds = $urandom_range(0, 2);
      if (quiet_tail && i >= count - QUIET_TAIL) idle_odds = 0;
      maybe_idle();
      send_request(random_frame());
    end
  endtask

  // Edge cases under the reset register values.
  task automatic run_directed();
    idle_odds = 1;
    // Lost marker spins whatever the command.
    send_frame(0, CMD_FOLLOW, 1000, 2000, 0, 0, 0, 0);
    send_frame(0, CMD_STOP, -32768, 32767, 32767, 32767, 32767, 32767);
    send_frame(0, CMD_UNDEF_LO, 32767, -32768, 15360, 15360, 15360, 15360);
    // Fixed modes.
    send_frame(1, CMD_LEFT, 5000, 30000, 0, 0, 0, 0);
    send_frame(1, CMD_RIGHT, -5000, -30000, 32767, 32767, 32767, 32767);
    send_frame(1, CMD_STOP, 32767, 32767, 100, 200, 300, 400);
    // Field extremes drive the rotation, forward and lateral limit clamps.
    send_frame(1, CMD_FOLLOW, 32767, 32767, 0, 0, 0, 0);
    send_frame(1, CMD_FOLLOW, -32768, -32768, 32767, 32767, 32767, 32767);
    send_frame(1, CMD_DOCK_A, 32767, 32767, 0, 0, 0, 0);
    send_frame(1, CMD_DOCK_B, -32768, -32768, 32767, 32767, 32767, 32767);
    // Follow-mode half gain rounds halves away from zero.
    send_frame(1, CMD_FOLLOW, 1, 1229, 15360, 15360, 15360, 15360);
    send_frame(1, CMD_FOLLOW, -1, 1229, 15360, 15360, 15360, 15360);
    send_frame(1, CMD_FOLLOW, 3, 1229, 15360, 15360, 15360, 15360);
    // Rotation and depth deadzone edges, both sides, both signs.
    send_frame(1, CMD_DOCK_A, 100, 1434, 14560, 14560, 14560, 14560);
    send_frame(1, CMD_DOCK_B, -100, 1435, 14560, 14560, 14560, 14559);
    send_frame(1, CMD_UNDEF_LO, 7, 1024, 16160, 16160, 16160, 16160);
    send_frame(1, CMD_UNDEF_HI, -7, 1023, 16160, 16160, 16160, 16161);
    // All-zero frame in follow and undefined modes.
    send_frame(1, CMD_FOLLOW, 0, 0, 0, 0, 0, 0);
    send_frame(1, CMD_UNDEF_HI, 0, 0, 0, 0, 0, 0);
  endtask

  initial begin
    cfg_t c;
    rst          <= 1'b1;
    start        <= 1'b0;
    target_found <= 1'b0;
    command      <= CMD_STOP;
    cam_x        <= '0;
    cam_z        <= '0;
    corner_x0    <= '0;
    corner_x1    <= '0;
    corner_x2    <= '0;
    corner_x3    <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_HALF_VIEW_WIDTH;
    cfg_data     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values first.
    run_directed();
    run_random(PHASE_ITEMS, 1'b0);

    // Every register at its maximum.
    wait_idle();
    c.half_view_width = '1;
    c.rotate_deadzone = '1;
    c.rotate_gain     = '1;
    c.depth_setpoint  = '1;
    c.depth_deadzone  = '1;
    c.forward_gain    = '1;
    c.lateral_gain    = '1;
    c.linear_limit    = '1;
    load_settings(c);
    run_random(PHASE_ITEMS, 1'b0);

    // Every register at zero.
    wait_idle();
    load_settings('0);
    run_random(PHASE_ITEMS, 1'b0);

    // Random settings.
    repeat (2) begin
      wait_idle();
      load_settings(random_settings());
      run_random(PHASE_ITEMS, 1'b0);
    end

    // Back to the reset values, ending with back-to-back requests.
    wait_idle();
    load_settings(sb.reset_values());
    run_random(PHASE_ITEMS, 1'b1);

    wait_idle();
    if (sb.failures == 0 && sb.pending_speeds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dzpv_pkg.sv
hw/rtl/dzpv_cfg.sv
hw/rtl/dzpv_front.sv
hw/rtl/dzpv_scale.sv
hw/rtl/dzpv_output.sv
hw/rtl/deadzone_p_velocity_controller.sv
bench/tb_deadzone_p_velocity_controller.sv
